/* src/udpcs_pkg.sv */
// Shared types and constants for the UDP receive checksum validator.
// Used by the front end, the packet queue, the back end and the top level.
package udpcs_pkg;

	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [15:0] HDR_BYTES = 16'd8;
	localparam logic [15:0] UDP_PROTO = 16'd17;
	localparam logic [15:0] MASK16    = 16'hFFFF;

	// Byte offsets of the header words within the datagram.
	localparam logic [15:0] OFF_SRC_PORT = 16'd0;
	localparam logic [15:0] OFF_DST_PORT = 16'd2;
	localparam logic [15:0] OFF_LENGTH   = 16'd4;
	localparam logic [15:0] OFF_CHECKSUM = 16'd6;

	typedef enum logic [1:0] {
		VERDICT_ACCEPT  = 2'd0,
		VERDICT_RUNT    = 2'd1,
		VERDICT_BAD_LEN = 2'd2,
		VERDICT_BAD_SUM = 2'd3
	} verdict_t;

	typedef struct packed {
		logic [15:0] data_word;
		logic        single_byte;
		logic        last_word;
		logic [31:0] source_addr;
		logic [31:0] target_addr;
	} in_item_t;

	typedef struct packed {
		verdict_t    verdict;
		logic [15:0] from_port;
		logic [15:0] to_port;
		logic [15:0] payload_bytes;
		logic [31:0] accepted_total;
		logic [31:0] dropped_total;
		logic [31:0] bad_sum_total;
	} out_item_t;

	// Per-packet summary handed from the front end to the back end.
	typedef struct packed {
		logic [15:0] sum;
		logic [15:0] byte_count;
		logic [15:0] from_port;
		logic [15:0] dst_port;
		logic [15:0] length;
		logic [15:0] checksum;
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
	} pkt_rec_t;

endpackage

/* src/udpcs_front.sv */
// Front end: takes packet words, captures the header, counts bytes and sums.
// Depends on udpcs_pkg; pushes one summary per packet into the queue.
module udpcs_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  udpcs_pkg::in_item_t item,
	output logic                rec_valid,
	input  logic                rec_ready,
	output udpcs_pkg::pkt_rec_t rec
);
	import udpcs_pkg::*;

	logic [15:0] count_q;
	logic [15:0] sum_q;
	logic [15:0] from_port_q;
	logic [15:0] dst_port_q;
	logic [15:0] length_q;
	logic [15:0] checksum_q;

	logic        single;
	logic [15:0] word;
	logic [15:0] addend;
	logic [16:0] raw_sum;
	logic [15:0] sum_next;
	logic [15:0] from_port_next;
	logic [15:0] dst_port_next;
	logic [15:0] length_next;
	logic [15:0] checksum_next;
	logic [16:0] count_raw;
	logic [15:0] count_next;
	logic [16:0] off_plus1;
	logic        take;

	assign item_ready = rec_ready;
	assign take       = item_valid && item_ready;

	always_comb begin
		single         = item.last_word && item.single_byte;
		word           = single ? {item.data_word[15:8], 8'h00} : item.data_word;
		off_plus1      = {1'b0, count_q} + 17'd1;
		addend         = '0;
		from_port_next = from_port_q;
		dst_port_next  = dst_port_q;
		length_next    = length_q;
		checksum_next  = checksum_q;
		if (count_q == OFF_SRC_PORT) begin
			from_port_next = word;
			addend         = word;
		end else if (count_q == OFF_DST_PORT) begin
			dst_port_next = word;
			addend        = word;
		end else if (count_q == OFF_LENGTH) begin
			length_next = word;
			addend      = word;
		end else if (count_q == OFF_CHECKSUM) begin
			checksum_next = word;
		end else if (count_q >= HDR_BYTES) begin
			// Bytes past the UDP length are counted but left out of the sum.
			if (count_q < length_q) begin
				addend[15:8] = word[15:8];
			end
			if (off_plus1 < {1'b0, length_q}) begin
				addend[7:0] = word[7:0];
			end
		end
		raw_sum   = {1'b0, sum_q} + {1'b0, addend};
		sum_next  = raw_sum[15:0] + {15'd0, raw_sum[16]};
		count_raw = {1'b0, count_q} + (single ? 17'd1 : 17'd2);
		count_next = count_raw[16] ? MASK16 : count_raw[15:0];
	end

	assign rec_valid = take && item.last_word;

	always_comb begin
		rec.sum        = sum_next;
		rec.byte_count = count_next;
		rec.from_port  = from_port_next;
		rec.dst_port   = dst_port_next;
		rec.length     = length_next;
		rec.checksum   = checksum_next;
		rec.src_addr   = item.source_addr;
		rec.dst_addr   = item.target_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			sum_q       <= '0;
			from_port_q <= '0;
			dst_port_q  <= '0;
			length_q    <= '0;
			checksum_q  <= '0;
		end else if (take) begin
			if (item.last_word) begin
				count_q     <= '0;
				sum_q       <= '0;
				from_port_q <= '0;
				dst_port_q  <= '0;
				length_q    <= '0;
				checksum_q  <= '0;
			end else begin
				count_q     <= count_next;
				sum_q       <= sum_next;
				from_port_q <= from_port_next;
				dst_port_q  <= dst_port_next;
				length_q    <= length_next;
				checksum_q  <= checksum_next;
			end
		end
	end

`ifndef SYNTHESIS
	// Only whole words arrive before the last one, so the count stays even.
	a_count_even: assert property (@(posedge clk) disable iff (!arst_n)
		count_q[0] |-> count_q == MASK16)
		else $error("byte count odd before saturation");

	// A last word always leaves the packet state cleared.
	a_clear_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		take && item.last_word |=> count_q == '0 && sum_q == '0)
		else $error("packet state not cleared after last word");

	// A summary is only pushed while the queue has room.
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid |-> rec_ready)
		else $error("summary pushed into a full queue");
`endif

endmodule

/* src/udpcs_queue.sv */
// Short queue of packet summaries between the front end and the back end.
// Depends on udpcs_pkg for the summary record type.
module udpcs_queue #(
	parameter int unsigned DEPTH = udpcs_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_valid,
	output logic                wr_ready,
	input  udpcs_pkg::pkt_rec_t wr_data,
	output logic                rd_valid,
	input  logic                rd_ready,
	output udpcs_pkg::pkt_rec_t rd_data
);
	import udpcs_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	pkt_rec_t           mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   fill_q;
	logic               push;
	logic               pop;

	assign wr_ready = fill_q != CNT_W'(DEPTH);
	assign rd_valid = fill_q != '0;
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;
	assign rd_data  = mem_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wrap_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= wrap_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				fill_q <= fill_q + CNT_W'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - CNT_W'(1);
			end
		end
	end

endmodule

/* src/udpcs_back.sv */
// Back end: adds the pseudo-header, checks length and checksum, keeps counters.
// Depends on udpcs_pkg; two pipeline stages, the second one is the output register.
module udpcs_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rec_valid,
	output logic                 rec_ready,
	input  udpcs_pkg::pkt_rec_t  rec,
	output logic                 result_valid,
	input  logic                 result_ready,
	output udpcs_pkg::out_item_t result
);
	import udpcs_pkg::*;

	// Stage 1: classification and two partial sums.
	logic        valid_s1;
	logic        runt_s1;
	logic        bad_len_s1;
	logic [17:0] part_a_s1;
	logic [17:0] part_b_s1;
	logic [15:0] length_s1;
	logic [15:0] checksum_s1;
	logic [15:0] from_port_s1;
	logic [15:0] dst_port_s1;

	// Stage 2: the result register.
	logic        valid_s2;
	out_item_t   result_s2;

	logic [31:0] accept_ctr_q;
	logic [31:0] drop_ctr_q;
	logic [31:0] sum_err_ctr_q;

	logic        adv_s2;
	logic        adv_s1;
	logic        load_s2;
	logic [18:0] total;
	logic [16:0] fold1;
	logic [15:0] fold2;
	logic [15:0] calc;
	verdict_t    verdict;
	logic        inc_accept;
	logic        inc_drop;
	logic        inc_sum_err;
	logic [31:0] accept_next;
	logic [31:0] drop_next;
	logic [31:0] sum_err_next;

	assign adv_s2    = !valid_s2 || result_ready;
	assign adv_s1    = !valid_s1 || adv_s2;
	assign rec_ready = adv_s1;
	assign load_s2   = valid_s1 && adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= rec_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && rec_valid) begin
			runt_s1      <= rec.byte_count < HDR_BYTES;
			bad_len_s1   <= rec.length < HDR_BYTES || rec.length > rec.byte_count;
			part_a_s1    <= {2'b00, rec.sum} + {2'b00, rec.src_addr[31:16]}
				+ {2'b00, rec.src_addr[15:0]} + {2'b00, rec.dst_addr[31:16]};
			part_b_s1    <= {2'b00, rec.dst_addr[15:0]} + {2'b00, UDP_PROTO}
				+ {2'b00, rec.length};
			length_s1    <= rec.length;
			checksum_s1  <= rec.checksum;
			from_port_s1 <= rec.from_port;
			dst_port_s1  <= rec.dst_port;
		end
	end

	// End-around-carry folding of the wide sum. The protocol word makes the
	// total nonzero, so the folded value lands in 1..0xFFFF as in serial form.
	always_comb begin
		total = {1'b0, part_a_s1} + {1'b0, part_b_s1};
		fold1 = {1'b0, total[15:0]} + {14'd0, total[18:16]};
		fold2 = fold1[15:0] + {15'd0, fold1[16]};
		calc  = ~fold2;
		if (calc == '0) begin
			calc = MASK16;
		end
		inc_accept  = 1'b0;
		inc_drop    = 1'b0;
		inc_sum_err = 1'b0;
		if (runt_s1) begin
			verdict  = VERDICT_RUNT;
			inc_drop = 1'b1;
		end else if (bad_len_s1) begin
			verdict  = VERDICT_BAD_LEN;
			inc_drop = 1'b1;
		end else if (checksum_s1 != '0 && checksum_s1 != calc) begin
			verdict     = VERDICT_BAD_SUM;
			inc_sum_err = 1'b1;
		end else begin
			verdict    = VERDICT_ACCEPT;
			inc_accept = 1'b1;
		end
		accept_next  = accept_ctr_q + {31'd0, inc_accept};
		drop_next    = drop_ctr_q + {31'd0, inc_drop};
		sum_err_next = sum_err_ctr_q + {31'd0, inc_sum_err};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2      <= 1'b0;
			accept_ctr_q  <= '0;
			drop_ctr_q    <= '0;
			sum_err_ctr_q <= '0;
		end else begin
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
			if (load_s2) begin
				accept_ctr_q  <= accept_next;
				drop_ctr_q    <= drop_next;
				sum_err_ctr_q <= sum_err_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			result_s2.verdict        <= verdict;
			result_s2.from_port      <= from_port_s1;
			result_s2.to_port        <= dst_port_s1;
			result_s2.payload_bytes  <= inc_accept ? length_s1 - HDR_BYTES : 16'd0;
			result_s2.accepted_total <= accept_next;
			result_s2.dropped_total  <= drop_next;
			result_s2.bad_sum_total  <= sum_err_next;
		end
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

`ifndef SYNTHESIS
	// Each packet bumps exactly one of the three counters.
	a_one_counter: assert property (@(posedge clk) disable iff (!arst_n)
		load_s2 |-> $onehot({inc_accept, inc_drop, inc_sum_err}))
		else $error("packet did not bump exactly one counter");

	// Only accepted packets report a payload length.
	a_payload_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && result_s2.verdict != VERDICT_ACCEPT |-> result_s2.payload_bytes == '0)
		else $error("payload length reported for a rejected packet");

	// Counters move only when a packet enters the result register.
	a_ctr_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!load_s2 |=> $stable(accept_ctr_q) && $stable(drop_ctr_q) && $stable(sum_err_ctr_q))
		else $error("counter changed without a packet");
`endif

endmodule

/* src/udp_rx_validate_checksum.sv */
// UDP receive validator: one 16-bit word per cycle, one verdict per packet.
// Throughput is one word every cycle; the front end never waits on the back end
// unless the summary queue (two entries by default) is full. A verdict passes the
// queue, the back end's classification stage and its output register in turn.
// Reset (arst_n low) clears the per-packet state, the queue, the pipeline and
// the accepted, dropped and checksum-error counters to zero.
module udp_rx_validate_checksum #(
	parameter int unsigned QUEUE_DEPTH = udpcs_pkg::QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  udpcs_pkg::in_item_t  item,
	output logic                 result_valid,
	input  logic                 result_ready,
	output udpcs_pkg::out_item_t result
);
	import udpcs_pkg::*;

	// The front end walks the datagram word by word. It captures the source
	// port, destination port, length and checksum at their fixed offsets,
	// keeps a saturating byte count, sums every in-length byte but the checksum
	// into a running ones-complement sum, and on the last word pushes one summary.
	logic     push_valid;
	logic     push_ready;
	pkt_rec_t push_rec;

	// Summaries leave the queue into the back end, which adds the
	// pseudo-header words and decides the verdict.
	logic     pop_valid;
	logic     pop_ready;
	pkt_rec_t pop_rec;

	udpcs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.rec_valid  (push_valid),
		.rec_ready  (push_ready),
		.rec        (push_rec)
	);

	// The queue lets a stalled output hold back up to QUEUE_DEPTH summaries,
	// beyond those in the back end, before the word stream itself sees backpressure.
	udpcs_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (push_valid),
		.wr_ready (push_ready),
		.wr_data  (push_rec),
		.rd_valid (pop_valid),
		.rd_ready (pop_ready),
		.rd_data  (pop_rec)
	);

	// The back end holds the wrapping counters and the output register, so
	// a finished verdict can wait for its transfer while the next one forms.
	udpcs_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.rec_valid    (pop_valid),
		.rec_ready    (pop_ready),
		.rec          (pop_rec),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule
